/* hdl/assert_macros.svh */
// Assertion macros shared by the fast-packet segmenter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define FPS_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) else $error(msg);

// Check that a trigger in one cycle implies a condition in the next one.
`define FPS_ASSERT_NEXT(lbl, clk_s, rstn_s, trig, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* hdl/fps_pkg.sv */
// Shared types and constants of the fast-packet segmenter.
`timescale 1ns / 1ps
`default_nettype none
package fps_pkg;

  localparam int FRAME_SLOTS         = 7;
  localparam int FIRST_FRAME_PAYLOAD = 6;
  localparam int LATER_FRAME_PAYLOAD = 7;
  localparam int MAX_MESSAGE_BYTES   = 223;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic [3:0] FULL_LENGTH_CODE = 4'd8;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [7:0]              seq;
    logic                    first;
    logic [7:0]              length;
    logic [FRAME_SLOTS-1:0][7:0] data;
    logic [2:0]              fill;
    logic                    last;
  } frame_rec_t;

endpackage
`default_nettype wire

/* hdl/fast_packet_segmenter.sv */
// Top level of the fast-packet segmenter.
`timescale 1ns / 1ps
`default_nettype none
// Takes one payload byte per beat and cuts each message into fast-packet CAN
// frames: a first frame with the sequence byte, the length byte and six payload
// bytes (length code 8), then frames of the sequence byte and up to seven bytes.
// The message length is sampled on the first byte of a message (0 reads as 1,
// values above MAX_MESSAGE_BYTES saturate). One byte is accepted every cycle
// while in_full is low; the byte that completes a frame writes the frame into
// the queue, and the frame moves on to the output register when it is free. A
// QUEUE_DEPTH-entry frame queue sits between front end and output register, and
// in_full rises only when that queue is full because results are not popped.
module fast_packet_segmenter #(
  parameter int MAX_MESSAGE_BYTES = fps_pkg::MAX_MESSAGE_BYTES,
  parameter int QUEUE_DEPTH       = fps_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_payload_byte,
  input  wire logic [7:0] in_message_length,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_frame_byte_0,
  output logic [7:0]      out_frame_byte_1,
  output logic [7:0]      out_frame_byte_2,
  output logic [7:0]      out_frame_byte_3,
  output logic [7:0]      out_frame_byte_4,
  output logic [7:0]      out_frame_byte_5,
  output logic [7:0]      out_frame_byte_6,
  output logic [7:0]      out_frame_byte_7,
  output logic [3:0]      out_frame_length,
  output logic            out_last_frame
);

  logic                in_accept;
  logic                rec_push;
  fps_pkg::frame_rec_t rec;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;
  fps_pkg::frame_rec_t q_rec;

  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  fps_front #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_accept),
    .payload_byte  (in_payload_byte),
    .message_length(in_message_length),
    .rec_push      (rec_push),
    .rec           (rec)
  );

  fps_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (rec_push),
    .push_rec(rec),
    .full    (q_full),
    .pop     (q_pop),
    .pop_rec (q_rec),
    .empty   (q_empty)
  );

  fps_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rec           (q_rec),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_frame_byte_0(out_frame_byte_0),
    .out_frame_byte_1(out_frame_byte_1),
    .out_frame_byte_2(out_frame_byte_2),
    .out_frame_byte_3(out_frame_byte_3),
    .out_frame_byte_4(out_frame_byte_4),
    .out_frame_byte_5(out_frame_byte_5),
    .out_frame_byte_6(out_frame_byte_6),
    .out_frame_byte_7(out_frame_byte_7),
    .out_frame_length(out_frame_length),
    .out_last_frame  (out_last_frame)
  );

endmodule
`default_nettype wire

/* hdl/fps_front.sv */
// Front end: take payload bytes, track message and frame position, cut frames.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fps_front #(
  parameter int MAX_MESSAGE_BYTES = fps_pkg::MAX_MESSAGE_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [7:0]        payload_byte,
  input  wire logic [7:0]        message_length,
  output logic                   rec_push,
  output fps_pkg::frame_rec_t    rec
);

  localparam logic [7:0] MAX_LEN   = 8'(MAX_MESSAGE_BYTES);
  localparam logic [2:0] CAP_FIRST = 3'(fps_pkg::FIRST_FRAME_PAYLOAD);
  localparam logic [2:0] CAP_LATER = 3'(fps_pkg::LATER_FRAME_PAYLOAD);

  logic [2:0] msg_id_r, msg_id_nxt;
  logic [4:0] frame_cnt_r, frame_cnt_nxt;
  logic [7:0] taken_r, taken_nxt;
  logic [7:0] len_r, len_nxt;
  logic [2:0] slot_r, slot_nxt;
  fps_pkg::byte_t buf_r [fps_pkg::FRAME_SLOTS];
  fps_pkg::byte_t buf_nxt [fps_pkg::FRAME_SLOTS];

  logic       start;
  logic [7:0] len_sat;
  logic [7:0] len_eff;
  logic [4:0] fcnt;
  logic [2:0] slot;
  logic [2:0] slot_inc;
  logic [7:0] taken_inc;
  logic       done;
  logic [2:0] cap;
  logic       emit;
  fps_pkg::byte_t fill_data [fps_pkg::FRAME_SLOTS];

  always_comb begin
    start = (taken_r == 8'd0);
    priority if (message_length == 8'd0) begin
      len_sat = 8'd1;
    end else if (message_length > MAX_LEN) begin
      len_sat = MAX_LEN;
    end else begin
      len_sat = message_length;
    end
    len_eff = start ? len_sat : len_r;
    fcnt    = start ? 5'd0 : frame_cnt_r;
    slot    = start ? 3'd0 : slot_r;
    for (int k = 0; k < fps_pkg::FRAME_SLOTS; k++) begin
      fill_data[k] = start ? 8'd0 : buf_r[k];
      if (slot == 3'(k)) begin
        fill_data[k] = payload_byte;
      end
    end
    slot_inc  = slot + 3'd1;
    taken_inc = taken_r + 8'd1;
    done      = (taken_inc >= len_eff);
    cap       = (fcnt == 5'd0) ? CAP_FIRST : CAP_LATER;
    emit      = (slot_inc >= cap) || done;
  end

  always_comb begin
    rec_push  = in_valid && emit;
    rec.seq   = {msg_id_r, fcnt};
    rec.first = (fcnt == 5'd0);
    rec.length = len_eff;
    for (int k = 0; k < fps_pkg::FRAME_SLOTS; k++) begin
      rec.data[k] = fill_data[k];
    end
    rec.fill = slot_inc;
    rec.last = done;
  end

  always_comb begin
    msg_id_nxt    = msg_id_r;
    frame_cnt_nxt = frame_cnt_r;
    taken_nxt     = taken_r;
    len_nxt       = len_r;
    slot_nxt      = slot_r;
    for (int k = 0; k < fps_pkg::FRAME_SLOTS; k++) begin
      buf_nxt[k] = buf_r[k];
    end
    if (in_valid) begin
      len_nxt = len_eff;
      if (emit) begin
        slot_nxt      = 3'd0;
        frame_cnt_nxt = fcnt + 5'd1;
        for (int k = 0; k < fps_pkg::FRAME_SLOTS; k++) begin
          buf_nxt[k] = 8'd0;
        end
        if (done) begin
          taken_nxt  = 8'd0;
          msg_id_nxt = msg_id_r + 3'd1;
        end else begin
          taken_nxt = taken_inc;
        end
      end else begin
        slot_nxt      = slot_inc;
        frame_cnt_nxt = fcnt;
        taken_nxt     = taken_inc;
        for (int k = 0; k < fps_pkg::FRAME_SLOTS; k++) begin
          buf_nxt[k] = fill_data[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_id_r    <= 3'd0;
      frame_cnt_r <= 5'd0;
      taken_r     <= 8'd0;
      len_r       <= 8'd0;
      slot_r      <= 3'd0;
    end else begin
      msg_id_r    <= msg_id_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      taken_r     <= taken_nxt;
      len_r       <= len_nxt;
      slot_r      <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < fps_pkg::FRAME_SLOTS; k++) begin
      buf_r[k] <= buf_nxt[k];
    end
  end

  `FPS_ASSERT_ALWAYS(a_idle_slot_zero, clk, rst_n, (taken_r != 8'd0) || (slot_r == 3'd0),
    "slot position left nonzero between messages")
  `FPS_ASSERT_ALWAYS(a_taken_below_len, clk, rst_n, taken_r < len_r || taken_r == 8'd0,
    "byte count reached message length without closing the message")
  `FPS_ASSERT_NEXT(a_id_advance, clk, rst_n, rec_push && rec.last,
    msg_id_r == 3'($past(msg_id_r) + 3'd1), "message id did not advance after last frame")

endmodule
`default_nettype wire

/* hdl/fps_queue.sv */
// Short frame queue between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fps_queue #(
  parameter int DEPTH = fps_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire fps_pkg::frame_rec_t push_rec,
  output logic                     full,
  input  wire logic                pop,
  output fps_pkg::frame_rec_t      pop_rec,
  output logic                     empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  fps_pkg::frame_rec_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  always_comb begin
    full    = (count_r == DEPTH_CNT);
    empty   = (count_r == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    pop_rec = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  `FPS_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= DEPTH_CNT,
    "frame queue count beyond depth")
  `FPS_ASSERT_NEXT(a_push_lands, clk, rst_n, push && !full && !pop, !empty,
    "frame queue empty after a push")

endmodule
`default_nettype wire

/* hdl/fps_back.sv */
// Output stage: lay out queued frames as CAN data bytes and hold them for the consumer.
`timescale 1ns / 1ps
`default_nettype none
module fps_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire fps_pkg::frame_rec_t q_rec,
  output logic                     q_pop,
  input  wire logic                out_pop,
  output logic                     out_empty,
  output logic [7:0]               out_frame_byte_0,
  output logic [7:0]               out_frame_byte_1,
  output logic [7:0]               out_frame_byte_2,
  output logic [7:0]               out_frame_byte_3,
  output logic [7:0]               out_frame_byte_4,
  output logic [7:0]               out_frame_byte_5,
  output logic [7:0]               out_frame_byte_6,
  output logic [7:0]               out_frame_byte_7,
  output logic [3:0]               out_frame_length,
  output logic                     out_last_frame
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r [8];
  logic [3:0] flen_r;
  logic       last_r;
  logic [7:0] byte_f [8];
  logic [3:0] flen_f;

  always_comb begin
    byte_f[0] = q_rec.seq;
    if (q_rec.first) begin
      byte_f[1] = q_rec.length;
      for (int k = 0; k < 6; k++) begin
        byte_f[2 + k] = q_rec.data[k];
      end
      flen_f = fps_pkg::FULL_LENGTH_CODE;
    end else begin
      for (int k = 0; k < 7; k++) begin
        byte_f[1 + k] = q_rec.data[k];
      end
      flen_f = {1'b0, q_rec.fill} + 4'd1;
    end
  end

  always_comb begin
    q_pop     = !q_empty && (!valid_r || out_pop);
    valid_nxt = q_pop || (valid_r && !out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int k = 0; k < 8; k++) begin
        byte_r[k] <= byte_f[k];
      end
      flen_r <= flen_f;
      last_r <= q_rec.last;
    end
  end

  assign out_empty        = !valid_r;
  assign out_frame_byte_0 = byte_r[0];
  assign out_frame_byte_1 = byte_r[1];
  assign out_frame_byte_2 = byte_r[2];
  assign out_frame_byte_3 = byte_r[3];
  assign out_frame_byte_4 = byte_r[4];
  assign out_frame_byte_5 = byte_r[5];
  assign out_frame_byte_6 = byte_r[6];
  assign out_frame_byte_7 = byte_r[7];
  assign out_frame_length = flen_r;
  assign out_last_frame   = last_r;

endmodule
`default_nettype wire

/* tb/fast_packet_segmenter_checker.sv */
// Checker for the fast-packet segmenter: frame predictor and result scoreboard.
`timescale 1ns / 1ps
module fast_packet_segmenter_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  logic [7:0] in_payload_byte,
  input  logic [7:0] in_message_length,
  input  logic       out_empty,
  input  logic       out_pop,
  input  logic [7:0] out_frame_byte_0,
  input  logic [7:0] out_frame_byte_1,
  input  logic [7:0] out_frame_byte_2,
  input  logic [7:0] out_frame_byte_3,
  input  logic [7:0] out_frame_byte_4,
  input  logic [7:0] out_frame_byte_5,
  input  logic [7:0] out_frame_byte_6,
  input  logic [7:0] out_frame_byte_7,
  input  logic [3:0] out_frame_length,
  input  logic       out_last_frame,
  output int         failures,
  output int         pending,
  output int         frames_checked
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [3:0]      code;
    logic            last;
  } can_frame_t;

  logic [2:0]      msg_id;
  logic [4:0]      frame_cnt;
  logic [7:0]      taken;
  logic [7:0]      msg_len;
  logic [2:0]      slot;
  logic [6:0][7:0] slots;

  can_frame_t frame_q[$];

  task automatic segment_byte(input logic [7:0] data, input logic [7:0] len_field);
    int len;
    int cap;
    bit done;
    can_frame_t f;
    if (taken == 8'd0) begin
      len = len_field;
      if (len == 0) len = 1;
      if (len > fps_pkg::MAX_MESSAGE_BYTES) len = fps_pkg::MAX_MESSAGE_BYTES;
      msg_len = 8'(len);
      frame_cnt = '0;
      slot = '0;
      slots = '0;
    end
    slots[slot] = data;
    slot = slot + 3'd1;
    taken = taken + 8'd1;
    cap = (frame_cnt == 5'd0) ? fps_pkg::FIRST_FRAME_PAYLOAD : fps_pkg::LATER_FRAME_PAYLOAD;
    done = (taken >= msg_len);
    if (int'(slot) >= cap || done) begin
      f = '0;
      f.bytes[0] = {msg_id, frame_cnt};
      if (frame_cnt == 5'd0) begin
        f.bytes[1] = msg_len;
        for (int k = 0; k < fps_pkg::FIRST_FRAME_PAYLOAD; k++) f.bytes[2 + k] = slots[k];
        f.code = fps_pkg::FULL_LENGTH_CODE;
      end else begin
        for (int k = 0; k < fps_pkg::LATER_FRAME_PAYLOAD; k++) f.bytes[1 + k] = slots[k];
        f.code = 4'(slot) + 4'd1;
      end
      f.last = done;
      frame_q.push_back(f);
      slots = '0;
      slot = '0;
      frame_cnt = frame_cnt + 5'd1;
      if (done) begin
        taken = '0;
        msg_id = msg_id + 3'd1;
      end
    end
  endtask

  task automatic note_failure(input string field, input logic [7:0] want, input logic [7:0] got);
    failures++;
    if (failures <= REPORT_LIMIT)
      $display("%0t: frame %0d %s mismatch: expected 0x%02h, got 0x%02h",
               $realtime, frames_checked, field, want, got);
  endtask

  task automatic check_frame();
    can_frame_t want;
    can_frame_t got;
    got.bytes = {out_frame_byte_7, out_frame_byte_6, out_frame_byte_5, out_frame_byte_4,
                 out_frame_byte_3, out_frame_byte_2, out_frame_byte_1, out_frame_byte_0};
    got.code = out_frame_length;
    got.last = out_last_frame;
    if (frame_q.size() == 0) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("%0t: unexpected frame, sequence byte 0x%02h", $realtime, got.bytes[0]);
    end else begin
      want = frame_q.pop_front();
      for (int k = 0; k < 8; k++)
        if (got.bytes[k] !== want.bytes[k])
          note_failure($sformatf("frame_byte_%0d", k), want.bytes[k], got.bytes[k]);
      if (got.code !== want.code)
        note_failure("frame_length", 8'(want.code), 8'(got.code));
      if (got.last !== want.last)
        note_failure("last_frame", 8'(want.last), 8'(got.last));
    end
    frames_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      msg_id = '0;
      frame_cnt = '0;
      taken = '0;
      msg_len = '0;
      slot = '0;
      slots = '0;
      frame_q.delete();
      pending = 0;
    end else begin
      if (in_push && !in_full) segment_byte(in_payload_byte, in_message_length);
      if (out_pop && !out_empty) check_frame();
      pending = frame_q.size();
    end
  end

endmodule

/* tb/fast_packet_segmenter_tb.sv */
// Testbench top for the fast-packet segmenter: clock, reset, beat stimulus and verdict.
`timescale 1ns / 1ps
module fast_packet_segmenter_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASE_BYTES    = 400;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_push = 1'b0;
  fps_pkg::byte_t in_payload_byte = '0;
  fps_pkg::byte_t in_message_length = '0;
  logic           out_pop = 1'b0;

  logic       in_full;
  logic       out_empty;
  logic [7:0] out_frame_byte_0;
  logic [7:0] out_frame_byte_1;
  logic [7:0] out_frame_byte_2;
  logic [7:0] out_frame_byte_3;
  logic [7:0] out_frame_byte_4;
  logic [7:0] out_frame_byte_5;
  logic [7:0] out_frame_byte_6;
  logic [7:0] out_frame_byte_7;
  logic [3:0] out_frame_length;
  logic       out_last_frame;

  int failures;
  int pending;
  int frames_checked;
  int tx_idle_pct = 10;
  int rx_idle_pct = 64;
  int messages_sent = 0;
  int bytes_sent = 0;
  int stall_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fast_packet_segmenter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_payload_byte  (in_payload_byte),
    .in_message_length(in_message_length),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_frame_byte_0 (out_frame_byte_0),
    .out_frame_byte_1 (out_frame_byte_1),
    .out_frame_byte_2 (out_frame_byte_2),
    .out_frame_byte_3 (out_frame_byte_3),
    .out_frame_byte_4 (out_frame_byte_4),
    .out_frame_byte_5 (out_frame_byte_5),
    .out_frame_byte_6 (out_frame_byte_6),
    .out_frame_byte_7 (out_frame_byte_7),
    .out_frame_length (out_frame_length),
    .out_last_frame   (out_last_frame)
  );

  fast_packet_segmenter_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_payload_byte  (in_payload_byte),
    .in_message_length(in_message_length),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_frame_byte_0 (out_frame_byte_0),
    .out_frame_byte_1 (out_frame_byte_1),
    .out_frame_byte_2 (out_frame_byte_2),
    .out_frame_byte_3 (out_frame_byte_3),
    .out_frame_byte_4 (out_frame_byte_4),
    .out_frame_byte_5 (out_frame_byte_5),
    .out_frame_byte_6 (out_frame_byte_6),
    .out_frame_byte_7 (out_frame_byte_7),
    .out_frame_length (out_frame_length),
    .out_last_frame   (out_last_frame),
    .failures         (failures),
    .pending          (pending),
    .frames_checked   (frames_checked)
  );

  always @(negedge clk) out_pop <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("fast_packet_segmenter test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_beat(input fps_pkg::byte_t data, input fps_pkg::byte_t len_field);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_payload_byte <= data;
    in_message_length <= len_field;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input fps_pkg::byte_t len_field, input bit patterned);
    int count;
    fps_pkg::byte_t data;
    count = (len_field == 8'd0) ? 1 :
            (int'(len_field) > fps_pkg::MAX_MESSAGE_BYTES) ? fps_pkg::MAX_MESSAGE_BYTES :
            int'(len_field);
    for (int k = 0; k < count; k++) begin
      data = patterned ? (bytes_sent[0] ? 8'hFF : 8'h00) : fps_pkg::byte_t'($urandom);
      if (k == 0) push_beat(data, len_field);
      else push_beat(data, patterned ? 8'hFF : fps_pkg::byte_t'($urandom));
    end
    messages_sent++;
  endtask

  task automatic send_random_messages(input int target);
    int start;
    int pick;
    fps_pkg::byte_t len_field;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      pick = $urandom_range(99);
      if (pick < 4) len_field = 8'd0;
      else if (pick < 8)
        len_field = fps_pkg::byte_t'($urandom_range(255, fps_pkg::MAX_MESSAGE_BYTES + 1));
      else if (pick < 18)
        len_field = fps_pkg::byte_t'($urandom_range(fps_pkg::MAX_MESSAGE_BYTES, 100));
      else len_field = fps_pkg::byte_t'($urandom_range(20, 1));
      send_message(len_field, 1'b0);
    end
  endtask

  task automatic wait_all_frames();
    in_push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_message(8'd0, 1'b1);
    send_message(8'd1, 1'b1);
    send_message(8'd2, 1'b1);
    send_message(8'd6, 1'b1);
    send_message(8'd7, 1'b1);
    wait_all_frames();

    send_random_messages(PHASE_BYTES);
    wait_all_frames();

    tx_idle_pct = 64;
    rx_idle_pct = 10;
    send_random_messages(PHASE_BYTES);
    wait_all_frames();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_message(8'(fps_pkg::MAX_MESSAGE_BYTES), 1'b0);
    send_message(8'd255, 1'b0);
    send_random_messages(PHASE_BYTES - 2 * fps_pkg::MAX_MESSAGE_BYTES);
    wait_all_frames();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d messages (%0d payload beats), length fields 0 to 255.",
             messages_sent, bytes_sent);
    $display("Checked %0d frames under three sender/receiver idle mixes.", frames_checked);
    if (failures == 0) begin
      $display("fast_packet_segmenter test passed");
    end else begin
      $display("fast_packet_segmenter test failed");
    end
    $finish;
  end

endmodule
